// ----- rtl/core/pol_pkg.sv -----
// Shared constants for the positional ordered list: widths, opcodes, status codes.
`default_nettype none

package pol_pkg;

  localparam int CAP_DEFAULT = 32;   // default list capacity
  localparam int MAX_RESULTS = 32;   // most elements one dump emits

  localparam int OPCODE_W   = 3;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 6;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 6;

  localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_DUMP      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/core/pol_if.sv -----
// Valid/ready channel interfaces for list commands and list results.
`default_nettype none

interface pol_in_if import pol_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic        [OPCODE_W-1:0]   opcode;
  logic signed [VALUE_W-1:0]    value;
  logic        [POSITION_W-1:0] position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface pol_out_if import pol_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic        [STATUS_W-1:0] status;
  logic        [COUNT_W-1:0]  element_count;
  logic signed [VALUE_W-1:0]  element_value;
  logic                       element_valid;
  logic                       last_result;

  modport source (output valid, output status, output element_count, output element_value,
                  output element_valid, output last_result, input ready);
  modport sink   (input valid, input status, input element_count, input element_value,
                  input element_valid, input last_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pol_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module pol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/positional_ordered_list.sv -----
// Positional ordered list: RAM-held element array with shift-on-insert/delete and dump.
// Insert moves the elements behind the position up one slot, back to front; delete moves
// them down one slot, front to back; one element moves per cycle through the RAM ports.
// Dump: elements go out from the front, one element per cycle while out is ready.
// Throughput: one command at a time; a new command is accepted once the previous is done.
// Reset: count cleared; RAM is not cleared, since only entries below the count are read.
`default_nettype none

module positional_ordered_list import pol_pkg::*; #(
  parameter int CAPACITY = CAP_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pol_in_if.sink     in_item,
  pol_out_if.source  out_item
);

  localparam int AW     = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int PW     = ((CNT_W > POSITION_W) ? CNT_W : POSITION_W) + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_SHIFT = 3'd1;
  localparam logic [2:0] S_INS_PUT   = 3'd2;
  localparam logic [2:0] S_DEL_SHIFT = 3'd3;
  localparam logic [2:0] S_RESP      = 3'd4;
  localparam logic [2:0] S_DUMP      = 3'd5;

  logic [2:0]              state_r,  state_nxt;
  logic [CNT_W-1:0]        total_r,  total_nxt;   // element count
  logic [AW-1:0]           ptr_r,    ptr_nxt;     // walking address
  logic [AW-1:0]           tgt_r,    tgt_nxt;     // insert slot (position - 1)
  logic [CNT_W-1:0]        dn_r,     dn_nxt;      // elements to dump
  logic [VALUE_W-1:0]      val_r,    val_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;

  // output register
  logic                    out_valid_r,  out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]      out_count_r,  out_count_nxt;
  logic [VALUE_W-1:0]      out_value_r,  out_value_nxt;
  logic                    out_evalid_r, out_evalid_nxt;
  logic                    out_last_r,   out_last_nxt;

  // RAM port
  logic                    wr_en, rd_en;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic [VALUE_W-1:0]      wr_data, rd_data;

  // command decode
  logic [PW-1:0]           n_ext, eff_pos;
  logic                    ins_ok, del_ok, is_full, out_free;

  pol_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_item.ready          = (state_r == S_IDLE);
  assign out_item.valid         = out_valid_r;
  assign out_item.status        = out_status_r;
  assign out_item.element_count = out_count_r;
  assign out_item.element_value = $signed(out_value_r);
  assign out_item.element_valid = out_evalid_r;
  assign out_item.last_result   = out_last_r;

  // Resolve front/back opcodes to a 1-based position.
  always_comb begin
    n_ext = PW'(total_r);
    case (in_item.opcode)
      OP_INS_FRONT, OP_DEL_FRONT: eff_pos = PW'(1);
      OP_INS_BACK:                eff_pos = n_ext + PW'(1);
      OP_DEL_BACK:                eff_pos = n_ext;
      default:                    eff_pos = PW'(in_item.position);
    endcase
  end

  // position check precedes the full check
  assign ins_ok   = (eff_pos != '0) && (eff_pos <= n_ext + PW'(1));
  assign del_ok   = (eff_pos != '0) && (eff_pos <= n_ext);
  assign is_full  = (int'(total_r) >= CAPACITY);
  assign out_free = !out_valid_r || out_item.ready;

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    ptr_nxt        = ptr_r;
    tgt_nxt        = tgt_r;
    dn_nxt         = dn_r;
    val_nxt        = val_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_value_nxt  = out_value_r;
    out_evalid_nxt = out_evalid_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;

    if (out_valid_r && out_item.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_item.valid) begin
          case (in_item.opcode)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
              if (!ins_ok) begin
                status_nxt = ST_IGNORED;
                state_nxt  = S_RESP;
              end else if (is_full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                status_nxt = ST_DONE;
                val_nxt    = $unsigned(in_item.value);
                tgt_nxt    = AW'(eff_pos - PW'(1));
                if (eff_pos <= n_ext) begin
                  // open a gap: move the tail up one slot, back to front
                  rd_en     = 1'b1;
                  rd_addr   = AW'(total_r - 1'b1);
                  ptr_nxt   = AW'(total_r);
                  state_nxt = S_INS_SHIFT;
                end else begin
                  state_nxt = S_INS_PUT;
                end
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
              if (!del_ok) begin
                status_nxt = ST_IGNORED;
                state_nxt  = S_RESP;
              end else begin
                status_nxt = ST_DONE;
                if (eff_pos < n_ext) begin
                  // close the gap: move the tail down one slot, front to back
                  rd_en     = 1'b1;
                  rd_addr   = AW'(eff_pos);
                  ptr_nxt   = AW'(eff_pos - PW'(1));
                  state_nxt = S_DEL_SHIFT;
                end else begin
                  total_nxt = total_r - 1'b1;
                  state_nxt = S_RESP;
                end
              end
            end
            OP_DUMP: begin
              status_nxt = ST_DONE;
              if (total_r == '0) begin
                state_nxt = S_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                ptr_nxt   = '0;
                dn_nxt    = (int'(total_r) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : total_r;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              status_nxt = ST_IGNORED;
              state_nxt  = S_RESP;
            end
          endcase
        end
      end

      S_INS_SHIFT: begin
        // read of ptr-1 landed; store it at ptr
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data;
        if ((ptr_r - 1'b1) == tgt_r) begin
          state_nxt = S_INS_PUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(int'(ptr_r) - 2);
          ptr_nxt = ptr_r - 1'b1;
        end
      end

      S_INS_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = tgt_r;
        wr_data   = val_r;
        total_nxt = total_r + 1'b1;
        state_nxt = S_RESP;
      end

      S_DEL_SHIFT: begin
        // read of ptr+1 landed; store it at ptr
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data;
        if ((CNT_W'(ptr_r) + CNT_W'(2)) == total_r) begin
          total_nxt = total_r - 1'b1;
          state_nxt = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(int'(ptr_r) + 2);
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = COUNT_W'(total_r);
          out_value_nxt  = '0;
          out_evalid_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_DUMP: begin
        // RAM data holds while the output stalls (no new read issued)
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_count_nxt  = COUNT_W'(total_r);
          out_value_nxt  = rd_data;
          out_evalid_nxt = 1'b1;
          if ((CNT_W'(ptr_r) + 1'b1) == dn_r) begin
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            out_last_nxt = 1'b0;
            rd_en        = 1'b1;
            rd_addr      = ptr_r + 1'b1;
            ptr_nxt      = ptr_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    tgt_r        <= tgt_nxt;
    dn_r         <= dn_nxt;
    val_r        <= val_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_value_r  <= out_value_nxt;
    out_evalid_r <= out_evalid_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

`default_nettype wire
